// File: design/alcu_pkg.sv
// Shared widths, constants and types for the aging life cell update block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package alcu_pkg;

  // Field widths
  localparam int AgeW   = 11;
  localparam int MaskW  = 8;
  localparam int CoordW = 9;
  localparam int CntW   = 4;
  localparam int RegW   = 10;
  localparam int IdxW   = 2;
  localparam int HashW  = 64;
  localparam int HalfW  = HashW / 2;

  // Default parameters
  localparam int GridSizeDefault   = 512;
  localparam int QueueDepthDefault = 2;

  // Hash finaliser
  localparam logic [HashW-1:0] MixMulA  = 64'hff51afd7ed558ccd;
  localparam logic [HashW-1:0] MixMulB  = 64'hc4ceb9fe1a85ec53;
  localparam int               MixShift = 33;

  // Remainder unit: hash bits consumed per cycle
  localparam int ModBits   = 8;
  localparam int ModChunks = HashW / ModBits;

  // Life rules
  localparam logic [AgeW-1:0] AgeMax     = 11'd2047;
  localparam logic [CntW-1:0] LonelyMax  = 4'd1;
  localparam logic [CntW-1:0] CrowdMin   = 4'd4;
  localparam logic [CntW-1:0] BirthCount = 4'd4;

  // Register reset values
  localparam logic [RegW-1:0] MaxLifeBaseRst   = 10'd800;
  localparam logic [RegW-1:0] MinLifeBaseRst   = 10'd501;
  localparam logic [RegW-1:0] MaxSlackRangeRst = 10'd720;
  localparam logic [RegW-1:0] MinSlackRangeRst = 10'd150;

  typedef enum logic [IdxW-1:0] {
    CfgMaxLifeBase   = 2'd0,
    CfgMinLifeBase   = 2'd1,
    CfgMaxSlackRange = 2'd2,
    CfgMinSlackRange = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RegW-1:0] max_life_base;
    logic [RegW-1:0] min_life_base;
    logic [RegW-1:0] max_slack_range;
    logic [RegW-1:0] min_slack_range;
  } cfg_t;

  // One classified cell waiting for the back end
  typedef struct packed {
    logic [AgeW-1:0]  age;
    logic [CntW-1:0]  count;
    logic [HashW-1:0] seed;
  } cell_item_t;

endpackage

`default_nettype wire

// File: design/alcu_if.sv
// Handshake channels of the aging life cell update block: cells in,
// next ages out, register writes. Depends on alcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface alcu_in_if import alcu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AgeW-1:0]   center_age;
  logic [MaskW-1:0]  neighbor_alive;
  logic [CoordW-1:0] col_index;
  logic [CoordW-1:0] row_index;

  modport source (output valid, center_age, neighbor_alive, col_index, row_index,
                  input ready);
  modport sink   (input valid, center_age, neighbor_alive, col_index, row_index,
                  output ready);
endinterface

interface alcu_out_if import alcu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AgeW-1:0] next_age;

  modport source (output valid, next_age, input ready);
  modport sink   (input valid, next_age, output ready);
endinterface

interface alcu_cfg_if import alcu_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] index;
  logic [RegW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/aging_life_cell_update.sv
// Aging life cell update: one cell beat in, its next age out.
// The back end takes one cell at a time: two hashes share one 32x32 multiplier,
// each followed by the remainder unit, and no new cell is taken before the
// output register is written; the queue in front of it holds waiting cells.
// Reset clears the entropy counter, the queue and the handshakes and loads the
// register defaults. Depends on alcu_pkg, alcu_if, alcu_front, alcu_fifo, alcu_back.
`timescale 1ns / 1ps
`default_nettype none

module aging_life_cell_update import alcu_pkg::*; #(
  parameter int GRID_SIZE   = GridSizeDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alcu_in_if.sink    in_i,
  alcu_out_if.source out_o,
  alcu_cfg_if.sink   cfg_i
);

  cfg_t       cfg_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  cell_item_t push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_life_base   <= MaxLifeBaseRst;
      cfg_q.min_life_base   <= MinLifeBaseRst;
      cfg_q.max_slack_range <= MaxSlackRangeRst;
      cfg_q.min_slack_range <= MinSlackRangeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgMaxLifeBase:   cfg_q.max_life_base   <= cfg_i.data;
        CfgMinLifeBase:   cfg_q.min_life_base   <= cfg_i.data;
        CfgMaxSlackRange: cfg_q.max_slack_range <= cfg_i.data;
        CfgMinSlackRange: cfg_q.min_slack_range <= cfg_i.data;
        default: ;
      endcase
    end
  end

  alcu_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  alcu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  alcu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .cfg_i       (cfg_q),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: design/alcu_front.sv
// Front end: takes a cell beat, counts the alive neighbours inside the grid
// and draws the hash seed from the entropy counter. Depends on alcu_pkg, alcu_if.
`timescale 1ns / 1ps
`default_nettype none

module alcu_front import alcu_pkg::*; #(
  parameter int GRID_SIZE = GridSizeDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  alcu_in_if.sink         in_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output cell_item_t      push_data_o
);

  logic [HashW-1:0] ctr_q, ctr_d;
  logic             x_lo, x_mid, x_hi, y_lo, y_mid, y_hi;
  logic [MaskW-1:0] in_grid;
  logic [MaskW-1:0] live;
  logic [CntW-1:0]  count;

  // Neighbour sides that stay on the grid; a cell off the grid sees the same test
  assign x_lo  = (in_i.col_index != '0) && (32'(in_i.col_index) <= 32'(GRID_SIZE));
  assign x_mid = (32'(in_i.col_index) < 32'(GRID_SIZE));
  assign x_hi  = (32'(in_i.col_index) < 32'(GRID_SIZE - 1));
  assign y_lo  = (in_i.row_index != '0) && (32'(in_i.row_index) <= 32'(GRID_SIZE));
  assign y_mid = (32'(in_i.row_index) < 32'(GRID_SIZE));
  assign y_hi  = (32'(in_i.row_index) < 32'(GRID_SIZE - 1));

  // Bit order: dx outer, dy inner, centre skipped
  assign in_grid = {x_hi & y_hi, x_hi & y_mid, x_hi & y_lo,
                    x_mid & y_hi, x_mid & y_lo,
                    x_lo & y_hi, x_lo & y_mid, x_lo & y_lo};
  assign live = in_i.neighbor_alive & in_grid;

  always_comb begin
    count = '0;
    for (int i = 0; i < MaskW; i++) begin
      count = count + CntW'(live[i]);
    end
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  assign push_data_o.age   = in_i.center_age;
  assign push_data_o.count = count;
  assign push_data_o.seed  = ctr_q + HashW'(1);

  // Two draws per cell: advance by two on each accepted beat
  assign ctr_d = (in_i.valid && push_ready_i) ? ctr_q + HashW'(2) : ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else begin
      ctr_q <= ctr_d;
    end
  end

endmodule

`default_nettype wire

// File: design/alcu_fifo.sv
// Short queue between front and back end, registers only.
// Depends on alcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alcu_fifo import alcu_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  output logic             push_ready_o,
  input  wire cell_item_t  push_data_i,
  output logic             pop_valid_o,
  input  wire logic        pop_ready_i,
  output cell_item_t       pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FillW = $clog2(DEPTH + 1);

  cell_item_t             slot_q [DEPTH];
  logic [PtrW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [FillW-1:0]       fill_q, fill_d;
  logic                   push, pop;

  assign push_ready_o = (fill_q != FillW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    fill_d = fill_q + FillW'(push) - FillW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/alcu_back.sv
// Back end: two hash finalisers on one shared 32x32 multiplier, an 8-bit-a-cycle
// remainder unit, the life rule and the output register. Depends on alcu_pkg, alcu_if.
`timescale 1ns / 1ps
`default_nettype none

module alcu_back import alcu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  output logic             pop_ready_o,
  input  wire cell_item_t  pop_data_i,
  input  wire cfg_t        cfg_i,
  alcu_out_if.source       out_o
);

  localparam int ChunkW = $clog2(ModChunks);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StMod  = 4'b0100,
    StDone = 4'b1000
  } back_state_e;

  back_state_e      state_q, state_d;
  cell_item_t       item_q, item_d;
  logic [HashW-1:0] h_q, h_d, acc_q, acc_d;
  logic [1:0]       step_q, step_d;
  logic             rnd_q, rnd_d, hsel_q, hsel_d;
  logic [RegW-1:0]  rem_q, rem_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic [RegW-1:0]  slack_max_q, slack_max_d, slack_min_q, slack_min_d;
  logic             out_valid_q, out_valid_d;
  logic [AgeW-1:0]  out_age_q, out_age_d;

  logic [HashW-1:0] mul_k;
  logic [HalfW-1:0] mul_a, mul_b;
  logic [HashW-1:0] prod, acc_sum, mixed;
  logic [RegW-1:0]  range, rem_next, slack;
  logic [AgeW-1:0]  max_life, min_life, age_inc, next_age;

  function automatic logic [HashW-1:0] premix(input logic [HashW-1:0] seed,
                                              input logic [CntW-1:0]  cnt,
                                              input logic [AgeW-1:0]  age);
    logic [HashW-1:0] v;
    v = seed ^ HashW'(cnt) ^ HashW'(age);
    return v ^ (v >> MixShift);
  endfunction

  // Low 64 bits of h * k as three 32x32 partial products, one a cycle
  assign mul_k = rnd_q ? MixMulB : MixMulA;

  always_comb begin
    unique case (step_q)
      2'd1: begin
        mul_a = h_q[HashW-1:HalfW];
        mul_b = mul_k[HalfW-1:0];
      end
      2'd2: begin
        mul_a = h_q[HalfW-1:0];
        mul_b = mul_k[HashW-1:HalfW];
      end
      default: begin
        mul_a = h_q[HalfW-1:0];
        mul_b = mul_k[HalfW-1:0];
      end
    endcase
  end

  assign prod    = HashW'(mul_a) * HashW'(mul_b);
  assign acc_sum = (step_q == 2'd0) ? prod : acc_q + {prod[HalfW-1:0], {HalfW{1'b0}}};
  assign mixed   = acc_sum ^ (acc_sum >> MixShift);

  // Restoring remainder, ModBits hash bits a cycle, most significant first
  assign range = hsel_q ? cfg_i.min_slack_range : cfg_i.max_slack_range;

  always_comb begin
    logic [RegW:0] r;
    rem_next = rem_q;
    for (int i = 0; i < ModBits; i++) begin
      r = {rem_next, h_q[HashW-1-i]};
      if (r >= {1'b0, range}) begin
        r = r - {1'b0, range};
      end
      rem_next = r[RegW-1:0];
    end
  end

  assign slack = (range == '0) ? '0 : rem_next;

  // Life rule
  assign max_life = {1'b0, cfg_i.max_life_base} + {1'b0, slack_max_q};
  assign min_life = {1'b0, cfg_i.min_life_base} + {1'b0, slack_min_q};
  assign age_inc  = (item_q.age == AgeMax) ? AgeMax : item_q.age + AgeW'(1);

  always_comb begin
    if (item_q.age == '0) begin
      next_age = (item_q.count == BirthCount) ? AgeW'(1) : '0;
    end else if (item_q.age < min_life) begin
      next_age = age_inc;
    end else if (item_q.count <= LonelyMax || item_q.count >= CrowdMin ||
                 item_q.age >= max_life) begin
      next_age = '0;
    end else begin
      next_age = age_inc;
    end
  end

  assign pop_ready_o  = (state_q == StIdle);
  assign out_o.valid    = out_valid_q;
  assign out_o.next_age = out_age_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    h_d         = h_q;
    acc_d       = acc_q;
    step_d      = step_q;
    rnd_d       = rnd_q;
    hsel_d      = hsel_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    slack_max_d = slack_max_q;
    slack_min_d = slack_min_q;
    out_age_d   = out_age_q;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      StIdle: begin
        if (pop_valid_i) begin
          item_d  = pop_data_i;
          h_d     = premix(pop_data_i.seed, pop_data_i.count, pop_data_i.age);
          step_d  = 2'd0;
          rnd_d   = 1'b0;
          hsel_d  = 1'b0;
          state_d = StMul;
        end
      end
      StMul: begin
        acc_d = acc_sum;
        if (step_q == 2'd2) begin
          h_d    = mixed;
          step_d = 2'd0;
          if (!rnd_q) begin
            rnd_d = 1'b1;
          end else begin
            rem_d   = '0;
            chunk_d = '0;
            state_d = StMod;
          end
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      StMod: begin
        h_d     = h_q << ModBits;
        rem_d   = rem_next;
        chunk_d = chunk_q + ChunkW'(1);
        if (chunk_q == ChunkW'(ModChunks - 1)) begin
          if (!hsel_q) begin
            // Second draw for the minimum lifespan
            slack_max_d = slack;
            hsel_d      = 1'b1;
            h_d         = premix(item_q.seed + HashW'(1), item_q.count, item_q.age);
            rnd_d       = 1'b0;
            step_d      = 2'd0;
            state_d     = StMul;
          end else begin
            slack_min_d = slack;
            state_d     = StDone;
          end
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_age_d   = next_age;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      rnd_q       <= 1'b0;
      hsel_q      <= 1'b0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      hsel_q      <= hsel_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    h_q         <= h_d;
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    slack_max_q <= slack_max_d;
    slack_min_q <= slack_min_d;
    out_age_q   <= out_age_d;
  end

endmodule

`default_nettype wire

// File: sim/aging_life_cell_update_tb.sv
`timescale 1ns / 1ps
// Testbench of the aging life cell update block: a directed table of cells,
// then randomised phases under several register settings, each beat checked.
// Depends on alcu_pkg, alcu_if and aging_life_cell_update.

module aging_life_cell_update_tb import alcu_pkg::*; ();

  localparam int HalfPeriod    = 6;
  localparam int ResetCycles   = 7;
  localparam int GridSize      = GridSizeDefault;
  localparam int CycleLimit    = 600000;
  localparam int DrainCycles   = 64;
  localparam int RandPhases    = 6;
  localparam int CellsPerPhase = 100;
  localparam int QuietPhase    = 4;

  // Register settings of the directed table
  localparam logic [1:0] PhReset = 2'd0;
  localparam logic [1:0] PhZero  = 2'd1;
  localparam logic [1:0] PhMax   = 2'd2;

  typedef struct packed {
    logic [AgeW-1:0]   age;
    logic [MaskW-1:0]  mask;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } cell_t;

  typedef struct packed {
    logic [1:0]      phase;
    cell_t           stim;
    logic            known;
    logic [AgeW-1:0] next_age;
  } dir_row_t;

  localparam cfg_t DirCfg [3] = '{
    '{MaxLifeBaseRst, MinLifeBaseRst, MaxSlackRangeRst, MinSlackRangeRst},
    '{10'd0, 10'd0, 10'd0, 10'd0},
    '{10'd1023, 10'd1023, 10'd1023, 10'd1023}
  };

  // known = 0 rows take their next age from the predictor
  localparam int NumDir = 25;
  localparam dir_row_t DirTab [NumDir] = '{
    '{PhReset, '{11'd0,    8'h00, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'hFF, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'h0F, 9'd5,   9'd5},   1'b1, 11'd1},
    '{PhReset, '{11'd0,    8'hF0, 9'd5,   9'd5},   1'b1, 11'd1},
    '{PhReset, '{11'd0,    8'h78, 9'd0,   9'd5},   1'b1, 11'd1},
    '{PhReset, '{11'd0,    8'h0F, 9'd0,   9'd5},   1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'hFF, 9'd0,   9'd0},   1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'hFF, 9'd511, 9'd511}, 1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'hFF, 9'd511, 9'd0},   1'b1, 11'd0},
    '{PhReset, '{11'd0,    8'h1E, 9'd511, 9'd200}, 1'b1, 11'd1},
    '{PhReset, '{11'd0,    8'h4B, 9'd200, 9'd511}, 1'b1, 11'd1},
    '{PhReset, '{11'd0,    8'h56, 9'd200, 9'd0},   1'b1, 11'd1},
    '{PhReset, '{11'd1,    8'h00, 9'd5,   9'd5},   1'b1, 11'd2},
    '{PhReset, '{11'd1,    8'hFF, 9'd511, 9'd511}, 1'b1, 11'd2},
    '{PhReset, '{11'd500,  8'h07, 9'd5,   9'd5},   1'b1, 11'd501},
    '{PhReset, '{11'd2047, 8'h07, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhReset, '{11'd1520, 8'h03, 9'd300, 9'd300}, 1'b1, 11'd0},
    '{PhReset, '{11'd700,  8'h03, 9'd5,   9'd5},   1'b0, 11'd0},
    '{PhReset, '{11'd600,  8'h07, 9'd100, 9'd9},   1'b0, 11'd0},
    '{PhZero,  '{11'd5,    8'h03, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhZero,  '{11'd0,    8'h0F, 9'd5,   9'd5},   1'b1, 11'd1},
    '{PhZero,  '{11'd2046, 8'h07, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhMax,   '{11'd1022, 8'hAA, 9'd5,   9'd5},   1'b1, 11'd1023},
    '{PhMax,   '{11'd2046, 8'h03, 9'd5,   9'd5},   1'b1, 11'd0},
    '{PhMax,   '{11'd1500, 8'h06, 9'd5,   9'd5},   1'b0, 11'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  alcu_in_if  in_if  ();
  alcu_out_if out_if ();
  alcu_cfg_if cfg_if ();

  aging_life_cell_update #(
    .GRID_SIZE(GridSize)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  cfg_t            life_cfg;
  logic [HashW-1:0] entropy;
  logic [AgeW-1:0] next_age_q [$];
  logic [AgeW-1:0] want_age;
  bit              no_idle       = 1'b0;
  int              err_count     = 0;
  int              cells_sent    = 0;
  int              ages_checked  = 0;
  int              settings_used = 0;
  int              stall_left    = 0;
  int unsigned     cycle_count   = 0;

  function automatic logic [HashW-1:0] mix64(input logic [HashW-1:0] v);
    logic [HashW-1:0] h;
    h = v;
    h = h ^ (h >> MixShift);
    h = h * MixMulA;
    h = h ^ (h >> MixShift);
    h = h * MixMulB;
    h = h ^ (h >> MixShift);
    return h;
  endfunction

  function automatic logic [HashW-1:0] slack(input logic [HashW-1:0] h,
                                             input logic [RegW-1:0] range);
    if (range == '0) return '0;
    return h % {{(HashW-RegW){1'b0}}, range};
  endfunction

  // Count alive neighbours, dropping those that fall off the grid
  function automatic int live_count(input cell_t c);
    int n, b, nx, ny;
    n = 0;
    b = 0;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        if (dx != 0 || dy != 0) begin
          nx = int'(c.col) + dx;
          ny = int'(c.row) + dy;
          if (nx >= 0 && nx < GridSize && ny >= 0 && ny < GridSize && c.mask[b]) n++;
          b++;
        end
      end
    end
    return n;
  endfunction

  // Next age of one cell; advances the entropy counter by two
  function automatic logic [AgeW-1:0] advance_cell(input cell_t c);
    logic [HashW-1:0] max_life, min_life;
    logic [CntW-1:0]  n;
    logic [AgeW-1:0]  grown;
    n = CntW'(live_count(c));
    entropy  = entropy + HashW'(1);
    max_life = HashW'(life_cfg.max_life_base) +
               slack(mix64(entropy ^ HashW'(n) ^ HashW'(c.age)),
                     life_cfg.max_slack_range);
    entropy  = entropy + HashW'(1);
    min_life = HashW'(life_cfg.min_life_base) +
               slack(mix64(entropy ^ HashW'(n) ^ HashW'(c.age)),
                     life_cfg.min_slack_range);
    grown = (c.age >= AgeMax) ? AgeMax : c.age + AgeW'(1);
    if (c.age == '0) return (n == BirthCount) ? AgeW'(1) : '0;
    if (HashW'(c.age) < min_life) return grown;
    if (n <= LonelyMax || n >= CrowdMin || HashW'(c.age) >= max_life) return '0;
    return grown;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CoordW-1:0] pick_coord();
    int k;
    if ($urandom_range(0, 3) != 0) return CoordW'($urandom);
    k = $urandom_range(0, 3);
    // 0, 1, GridSize-2, GridSize-1
    return CoordW'((k < 2) ? k : GridSize - 4 + k);
  endfunction

  function automatic logic [RegW-1:0] rand_reg();
    return RegW'($urandom);
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int r, lo, hi;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      c.age = '0;
    end else if (r < 30) begin
      c.age = $urandom_range(0, 1) ? AgeMax - AgeW'($urandom_range(0, 1))
                                   : AgeW'($urandom_range(1, 2));
    end else if (r < 75) begin
      // aim at the band between the lifespans, where the rules bite
      lo = int'(life_cfg.min_life_base);
      hi = int'(life_cfg.max_life_base) + int'(life_cfg.max_slack_range);
      if (hi > int'(AgeMax)) hi = int'(AgeMax);
      c.age = AgeW'($urandom_range(hi, lo));
    end else begin
      c.age = AgeW'($urandom);
    end
    case ($urandom_range(0, 2))
      0: c.mask = MaskW'($urandom);
      1: c.mask = MaskW'($urandom & $urandom);
      default: begin
        c.mask = '0;
        repeat ($urandom_range(2, 4)) c.mask[$urandom_range(0, MaskW-1)] = 1'b1;
      end
    endcase
    c.col = pick_coord();
    c.row = pick_coord();
    return c;
  endfunction

  task automatic send_cell(input cell_t c, input logic known, input logic [AgeW-1:0] typed);
    int gap;
    logic took;
    logic [AgeW-1:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.center_age     <= c.age;
    in_if.neighbor_alive <= c.mask;
    in_if.col_index      <= c.col;
    in_if.row_index      <= c.row;
    // ready settles mid-cycle to the value the next rising edge sees
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    predicted = advance_cell(c);
    next_age_q.push_back(known ? typed : predicted);
    cells_sent++;
  endtask

  // Drop valid and wait for every outstanding next age
  task automatic finish_phase();
    in_if.valid <= 1'b0;
    while (next_age_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [RegW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CfgMaxLifeBase:   life_cfg.max_life_base   = val;
      CfgMinLifeBase:   life_cfg.min_life_base   = val;
      CfgMaxSlackRange: life_cfg.max_slack_range = val;
      CfgMinSlackRange: life_cfg.min_slack_range = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CfgMaxLifeBase,   s.max_life_base);
    write_reg(CfgMinLifeBase,   s.min_life_base);
    write_reg(CfgMaxSlackRange, s.max_slack_range);
    write_reg(CfgMinSlackRange, s.min_slack_range);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Result side: check each beat mid-cycle, where valid and ready hold steady
  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (next_age_q.size() == 0) begin
        $error("next_age: unexpected beat, got %0d", out_if.next_age);
        err_count++;
      end else begin
        want_age = next_age_q.pop_front();
        if (out_if.next_age !== want_age) begin
          $error("next_age: expected %0d, got %0d", want_age, out_if.next_age);
          err_count++;
        end
        ages_checked++;
      end
    end
  end

  // Pick the next ready with random stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    out_if.ready <= rst_ni && (stall_left == 0);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out with %0d next ages outstanding.", next_age_q.size());
      $display("aging_life_cell_update_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t       phase_cfg [RandPhases];
    logic [1:0] cur_phase;
    dir_row_t   row;

    in_if.valid          = 1'b0;
    in_if.center_age     = '0;
    in_if.neighbor_alive = '0;
    in_if.col_index      = '0;
    in_if.row_index      = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CfgMaxLifeBase;
    cfg_if.data          = '0;
    life_cfg = DirCfg[PhReset];
    entropy  = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_phase = PhReset;
    for (int i = 0; i < NumDir; i++) begin
      row = DirTab[i];
      if (row.phase != cur_phase) begin
        finish_phase();
        load_settings(DirCfg[row.phase]);
        cur_phase = row.phase;
      end
      send_cell(row.stim, row.known, row.next_age);
    end

    phase_cfg[0] = '{rand_reg(), rand_reg(), rand_reg(), rand_reg()};
    phase_cfg[1] = DirCfg[PhMax];
    phase_cfg[2] = '{10'd0, 10'd0, 10'd1, 10'd1};
    phase_cfg[3] = '{rand_reg(), rand_reg(), 10'd0, 10'd0};
    phase_cfg[4] = DirCfg[PhReset];
    phase_cfg[5] = '{rand_reg(), rand_reg(), RegW'($urandom_range(1, 16)),
                     RegW'($urandom_range(1, 16))};

    for (int p = 0; p < RandPhases; p++) begin
      finish_phase();
      load_settings(phase_cfg[p]);
      // hold both sides busy for one whole phase
      no_idle = (p == QuietPhase);
      repeat (CellsPerPhase) send_cell(random_cell(), 1'b0, '0);
    end
    finish_phase();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d cells and checked %0d next ages under %0d register settings,",
             cells_sent, ages_checked, settings_used + 1);
    $display("grid edges, births, deaths and zero slack ranges included.");
    if (err_count == 0) $display("aging_life_cell_update_tb: done, clean");
    else $display("aging_life_cell_update_tb: done, errors");
    $finish;
  end

endmodule
